### rtl/rrts_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the round-robin thread scheduler.
// No dependencies; the core imports it.
package rrts_pkg;

    typedef enum logic [1:0] {
        MODE_CREATE = 2'd0,
        MODE_YIELD  = 2'd1,
        MODE_EXIT   = 2'd2,
        MODE_JOIN   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        TS_FREE    = 2'd0,
        TS_ACTIVE  = 2'd1,
        TS_BLOCKED = 2'd2,
        TS_DEAD    = 2'd3
    } t_tstate;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_NO_THREADS = 3'd1,
        STS_FULL       = 3'd2,
        STS_UNKNOWN    = 3'd3,
        STS_NONE_RUN   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CREATE2,
        S_EXIT_RD,
        S_EXIT_WAKE,
        S_JOIN_RD,
        S_SCAN,
        S_OUT
    } t_fsm;

endpackage

### rtl/round_robin_thread_scheduler_core.sv
`timescale 1ns / 1ps
// Round-robin thread scheduler core: thread table in two synchronous memories
// and a sequencer that reads, updates and writes them back. Depends on rrts_pkg.
//
// Usage:
// - Input channel (i_valid / o_stall): one beat is one event, i_mode selects
//   create, yield, exit or join; i_target_id matters only for join. A beat is
//   taken while the sequencer is idle; o_stall stays high while an event is
//   being worked on.
// - Output channel (o_valid / i_stall): one beat per event carrying status,
//   the running id after the event, the id given by a create and a flag that
//   the running thread changed.
// - Yield and exit walk the thread states one entry per cycle through the state
//   memory read port; create, join and rejected events need no walk. One event
//   is in flight at a time.
// - The result waits in an output register; the next event is taken while it
//   waits, and only its own result is held back until the receiver drops
//   i_stall.
// - Reset: empty table, running id 1, next id 1. Table entries beyond the
//   next free id are never read, so the memories need no clearing pass.
module round_robin_thread_scheduler_core #(
    parameter int MAX_THREADS = 16,
    localparam int ID_W = $clog2(MAX_THREADS + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [1:0]      i_mode,
    input  logic [ID_W-1:0] i_target_id,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [2:0]      o_status,
    output logic [ID_W-1:0] o_running_id,
    output logic [ID_W-1:0] o_new_id,
    output logic            o_switched
);
    import rrts_pkg::*;

    localparam int CNT_W = $clog2(MAX_THREADS + 2);
    localparam int IDX_W = $clog2(MAX_THREADS);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_THREADS);
    localparam logic FIRST_FULL = (MAX_THREADS < 2);

    function automatic logic [IDX_W-1:0] to_idx(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] t;
        t = id - ID_W'(1);
        return t[IDX_W-1:0];
    endfunction

    // Thread table.
    t_tstate         r_st_mem [MAX_THREADS];
    logic [ID_W-1:0] r_jn_mem [MAX_THREADS];
    t_tstate         r_st_rd;
    logic [ID_W-1:0] r_jn_rd;

    logic            st_we, st_re, jn_we, jn_re;
    logic [IDX_W-1:0] st_waddr, st_raddr, jn_waddr, jn_raddr;
    t_tstate         st_wdata;
    logic [ID_W-1:0] jn_wdata;

    // Sequencer state.
    t_fsm             r_state, n_state;
    t_mode            r_mode, n_mode;
    logic [ID_W-1:0]  r_target, n_target;
    logic [ID_W-1:0]  r_running, n_running;
    logic [ID_W-1:0]  r_before, n_before;
    logic [CNT_W-1:0] r_next_free, n_next_free;
    t_status          r_status, n_status;
    logic [ID_W-1:0]  r_new_id, n_new_id;
    logic [ID_W-1:0]  r_cand, n_cand;
    logic [ID_W-1:0]  r_left, n_left;
    logic             r_chk_vld, n_chk_vld;
    logic [ID_W-1:0]  r_chk_id, n_chk_id;

    logic             r_out_vld, n_out_vld;
    t_status          r_out_status, n_out_status;
    logic [ID_W-1:0]  r_out_running, n_out_running;
    logic [ID_W-1:0]  r_out_new_id, n_out_new_id;
    logic             r_out_switched, n_out_switched;

    logic [CNT_W-1:0] last_c;
    logic [ID_W-1:0]  last_id;
    logic             run_valid, tgt_valid, full;
    logic [ID_W-1:0]  scan_start, scan_first, cand_wrap;

    assign last_c  = r_next_free - CNT_W'(1);
    assign last_id = last_c[ID_W-1:0];
    assign run_valid = (r_running != '0) && (r_running <= last_id);
    assign tgt_valid = (i_target_id != '0) && (i_target_id <= last_id);
    assign full = (r_next_free == CNT_W'(1)) ? FIRST_FULL : (r_next_free > MAX_C);

    // The walk starts after the running thread, or after the last id when
    // there is no valid running thread, so that it begins at id 1.
    assign scan_start = run_valid ? r_running : last_id;
    assign scan_first = (scan_start >= last_id) ? ID_W'(1) : scan_start + ID_W'(1);
    assign cand_wrap  = (r_cand >= last_id) ? ID_W'(1) : r_cand + ID_W'(1);

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_vld;
    assign o_status     = r_out_status;
    assign o_running_id = r_out_running;
    assign o_new_id     = r_out_new_id;
    assign o_switched   = r_out_switched;

    always_comb begin
        n_state        = r_state;
        n_mode         = r_mode;
        n_target       = r_target;
        n_running      = r_running;
        n_before       = r_before;
        n_next_free    = r_next_free;
        n_status       = r_status;
        n_new_id       = r_new_id;
        n_cand         = r_cand;
        n_left         = r_left;
        n_chk_vld      = r_chk_vld;
        n_chk_id       = r_chk_id;
        n_out_vld      = r_out_vld && i_stall;
        n_out_status   = r_out_status;
        n_out_running  = r_out_running;
        n_out_new_id   = r_out_new_id;
        n_out_switched = r_out_switched;
        st_we    = 1'b0;
        st_waddr = '0;
        st_wdata = TS_ACTIVE;
        st_re    = 1'b0;
        st_raddr = '0;
        jn_we    = 1'b0;
        jn_waddr = '0;
        jn_wdata = '0;
        jn_re    = 1'b0;
        jn_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode   = t_mode'(i_mode);
                    n_target = i_target_id;
                    n_before = r_running;
                    n_status = STS_OK;
                    n_new_id = '0;
                    n_state  = S_OUT;
                    if (t_mode'(i_mode) == MODE_CREATE) begin
                        if (full) begin
                            n_status = STS_FULL;
                        end else if (r_next_free == CNT_W'(1)) begin
                            // The first create registers the main thread as id 1.
                            st_we       = 1'b1;
                            st_waddr    = '0;
                            jn_we       = 1'b1;
                            jn_waddr    = '0;
                            n_next_free = CNT_W'(2);
                            n_state     = S_CREATE2;
                        end else begin
                            st_we       = 1'b1;
                            st_waddr    = to_idx(r_next_free[ID_W-1:0]);
                            jn_we       = 1'b1;
                            jn_waddr    = to_idx(r_next_free[ID_W-1:0]);
                            n_new_id    = r_next_free[ID_W-1:0];
                            n_next_free = r_next_free + CNT_W'(1);
                        end
                    end else if (r_next_free == CNT_W'(1)) begin
                        n_status = STS_NO_THREADS;
                    end else if (t_mode'(i_mode) == MODE_YIELD) begin
                        n_cand    = scan_first;
                        n_left    = last_id;
                        n_chk_vld = 1'b0;
                        n_state   = S_SCAN;
                    end else if (!run_valid) begin
                        n_status = STS_NONE_RUN;
                    end else if (t_mode'(i_mode) == MODE_EXIT) begin
                        jn_re    = 1'b1;
                        jn_raddr = to_idx(r_running);
                        n_state  = S_EXIT_RD;
                    end else if (!tgt_valid || i_target_id == r_running) begin
                        n_status = STS_UNKNOWN;
                    end else begin
                        st_re    = 1'b1;
                        st_raddr = to_idx(i_target_id);
                        n_state  = S_JOIN_RD;
                    end
                end
            end
            S_CREATE2: begin
                st_we       = 1'b1;
                st_waddr    = IDX_W'(1);
                jn_we       = 1'b1;
                jn_waddr    = IDX_W'(1);
                n_new_id    = ID_W'(2);
                n_next_free = CNT_W'(3);
                n_state     = S_OUT;
            end
            S_EXIT_RD: begin
                st_we    = 1'b1;
                st_waddr = to_idx(r_running);
                st_wdata = TS_DEAD;
                jn_we    = 1'b1;
                jn_waddr = to_idx(r_running);
                jn_wdata = '0;
                n_state  = S_EXIT_WAKE;
            end
            S_EXIT_WAKE: begin
                // r_jn_rd still holds the joiner of the exiting thread.
                if (r_jn_rd != '0 && r_jn_rd <= last_id) begin
                    st_we    = 1'b1;
                    st_waddr = to_idx(r_jn_rd);
                    st_wdata = TS_ACTIVE;
                end
                n_cand    = scan_first;
                n_left    = last_id;
                n_chk_vld = 1'b0;
                n_state   = S_SCAN;
            end
            S_JOIN_RD: begin
                if (r_st_rd == TS_ACTIVE) begin
                    st_we     = 1'b1;
                    st_waddr  = to_idx(r_running);
                    st_wdata  = TS_BLOCKED;
                    jn_we     = 1'b1;
                    jn_waddr  = to_idx(r_target);
                    jn_wdata  = r_running;
                    n_running = r_target;
                end
                n_state = S_OUT;
            end
            S_SCAN: begin
                // One state read is issued per cycle; the candidate issued in
                // the previous cycle is checked against the returned data.
                if (r_chk_vld && r_st_rd == TS_ACTIVE) begin
                    n_running = r_chk_id;
                    n_chk_vld = 1'b0;
                    n_state   = S_OUT;
                end else if (r_left == '0 && !r_chk_vld) begin
                    n_status = STS_NONE_RUN;
                    if (r_mode == MODE_EXIT) begin
                        n_running = '0;
                    end
                    n_state = S_OUT;
                end else if (r_left != '0) begin
                    st_re     = 1'b1;
                    st_raddr  = to_idx(r_cand);
                    n_chk_vld = 1'b1;
                    n_chk_id  = r_cand;
                    n_cand    = cand_wrap;
                    n_left    = r_left - ID_W'(1);
                end else begin
                    n_chk_vld = 1'b0;
                end
            end
            S_OUT: begin
                if (!r_out_vld || !i_stall) begin
                    n_out_vld      = 1'b1;
                    n_out_status   = r_status;
                    n_out_running  = r_running;
                    n_out_new_id   = r_new_id;
                    n_out_switched = (r_running != r_before);
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_running   <= ID_W'(1);
            r_next_free <= CNT_W'(1);
            r_chk_vld   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_running   <= n_running;
            r_next_free <= n_next_free;
            r_chk_vld   <= n_chk_vld;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode         <= n_mode;
        r_target       <= n_target;
        r_before       <= n_before;
        r_status       <= n_status;
        r_new_id       <= n_new_id;
        r_cand         <= n_cand;
        r_left         <= n_left;
        r_chk_id       <= n_chk_id;
        r_out_status   <= n_out_status;
        r_out_running  <= n_out_running;
        r_out_new_id   <= n_out_new_id;
        r_out_switched <= n_out_switched;
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_st_mem[st_waddr] <= st_wdata;
        end
        if (st_re) begin
            r_st_rd <= r_st_mem[st_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (jn_we) begin
            r_jn_mem[jn_waddr] <= jn_wdata;
        end
        if (jn_re) begin
            r_jn_rd <= r_jn_mem[jn_raddr];
        end
    end

    // Ids are handed out in order and never beyond the table size.
    a_next_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_free != '0) && (r_next_free <= MAX_C + CNT_W'(1)))
        else $error("next free id out of range");

    // The walk never has more candidates left than there are threads.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_left <= last_id))
        else $error("scan count exceeds thread count");

    // A finished event reaches the output register at the next edge.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_out_vld || !i_stall)) |=> (o_valid && r_state == S_IDLE))
        else $error("result not loaded into output register");

    // A later create extends the id range by exactly one.
    a_create_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid && i_mode == MODE_CREATE && !full
            && r_next_free != CNT_W'(1))
        |=> (r_next_free == $past(r_next_free) + CNT_W'(1)))
        else $error("create did not advance the next free id");

endmodule

### dv/round_robin_thread_scheduler_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for round_robin_thread_scheduler_core: a directed event table,
// then random event traffic, each beat checked against its typed row or a built-in model.
// Depends on rrts_pkg and the core RTL.
module round_robin_thread_scheduler_core_tb;
    import rrts_pkg::*;

    localparam int MAX_THREADS = 16;
    localparam int ID_W = 5;
    localparam int RANDOM_EVENTS = 1800;

    typedef struct packed {
        t_status         status;
        logic [ID_W-1:0] running_id;
        logic [ID_W-1:0] new_id;
        logic            switched;
    } t_sched_result;

    typedef struct {
        t_mode           mode;
        logic [ID_W-1:0] target;
        bit              typed;
        t_sched_result   want;
    } t_event_row;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_stall;
    logic [1:0]      i_mode;
    logic [ID_W-1:0] i_target_id;
    logic            o_valid;
    logic            i_stall;
    logic [2:0]      o_status;
    logic [ID_W-1:0] o_running_id;
    logic [ID_W-1:0] o_new_id;
    logic            o_switched;

    round_robin_thread_scheduler_core #(.MAX_THREADS(MAX_THREADS)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_target_id  (i_target_id),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_running_id (o_running_id),
        .o_new_id     (o_new_id),
        .o_switched   (o_switched)
    );

    // Scheduler image kept by the testbench.
    t_tstate         thread_tbl [1:MAX_THREADS];
    logic [ID_W-1:0] joined_by [1:MAX_THREADS];
    logic [ID_W-1:0] cur_thread;
    logic [ID_W-1:0] next_id;
    logic [ID_W-1:0] table_used;

    t_sched_result pending_results [$];
    int            error_count;
    int            burst_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8ms;
        $display("** round_robin_thread_scheduler_core: FAILED **");
        $finish;
    end

    function automatic bit is_issued(logic [ID_W-1:0] id);
        return id >= 1 && id <= next_id - 1'b1;
    endfunction

    // Next active id after 'from' in circular order, 0 when there is none.
    function automatic logic [ID_W-1:0] next_runnable(logic [ID_W-1:0] from);
        int n;
        int pos;
        n = int'(next_id) - 1;
        if (n == 0) return '0;
        pos = is_issued(from) ? int'(from) : n;
        for (int k = 0; k < n; k++) begin
            pos = (pos >= n) ? 1 : pos + 1;
            if (thread_tbl[pos] == TS_ACTIVE) return ID_W'(pos);
        end
        return '0;
    endfunction

    task automatic clear_scheduler();
        for (int i = 1; i <= MAX_THREADS; i++) begin
            thread_tbl[i] = TS_FREE;
            joined_by[i] = '0;
        end
        cur_thread = 1;
        next_id = 1;
        table_used = '0;
    endtask

    task automatic schedule_event(input t_mode mode, input logic [ID_W-1:0] tgt,
                                  output t_sched_result res);
        logic [ID_W-1:0] prev_thread;
        logic [ID_W-1:0] waker;
        logic [ID_W-1:0] pick;
        int need;
        prev_thread = cur_thread;
        res.status = STS_OK;
        res.new_id = '0;
        if (mode == MODE_CREATE) begin
            need = (table_used == 0) ? 2 : 1;
            if (int'(next_id) + need - 1 > MAX_THREADS) begin
                res.status = STS_FULL;
            end else begin
                // The first create also registers the main thread.
                if (table_used == 0) begin
                    thread_tbl[next_id] = TS_ACTIVE;
                    joined_by[next_id] = '0;
                    next_id++;
                    table_used++;
                end
                res.new_id = next_id;
                thread_tbl[next_id] = TS_ACTIVE;
                joined_by[next_id] = '0;
                next_id++;
                table_used++;
            end
        end else if (table_used == 0) begin
            res.status = STS_NO_THREADS;
        end else if (mode == MODE_YIELD) begin
            pick = next_runnable(cur_thread);
            if (pick == 0) res.status = STS_NONE_RUN;
            else cur_thread = pick;
        end else if (mode == MODE_EXIT) begin
            if (!is_issued(cur_thread)) begin
                res.status = STS_NONE_RUN;
            end else begin
                waker = joined_by[cur_thread];
                thread_tbl[cur_thread] = TS_DEAD;
                if (is_issued(waker)) thread_tbl[waker] = TS_ACTIVE;
                joined_by[cur_thread] = '0;
                pick = next_runnable(cur_thread);
                if (pick == 0) res.status = STS_NONE_RUN;
                cur_thread = pick;
            end
        end else begin
            if (!is_issued(cur_thread)) begin
                res.status = STS_NONE_RUN;
            end else if (!is_issued(tgt) || tgt == cur_thread) begin
                res.status = STS_UNKNOWN;
            end else if (thread_tbl[tgt] == TS_ACTIVE) begin
                // A later joiner replaces the recorded one.
                thread_tbl[cur_thread] = TS_BLOCKED;
                joined_by[tgt] = cur_thread;
                cur_thread = tgt;
            end
        end
        res.running_id = cur_thread;
        res.switched = cur_thread != prev_thread;
    endtask

    function automatic t_event_row make_row(t_mode mode, logic [ID_W-1:0] tgt, bit typed,
                                            t_status st, logic [ID_W-1:0] run,
                                            logic [ID_W-1:0] nid, logic sw);
        t_event_row row;
        row.mode = mode;
        row.target = tgt;
        row.typed = typed;
        row.want = '{status: st, running_id: run, new_id: nid, switched: sw};
        return row;
    endfunction

    // Called at a falling edge. Holds the beat until it is taken, then returns at the next
    // falling edge. The sender may pause between bursts of random length.
    task automatic send_event(input t_event_row row);
        t_sched_result res;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid = 1'b1;
        i_mode = row.mode;
        i_target_id = row.target;
        do @(posedge i_clk); while (o_stall);
        schedule_event(row.mode, row.target, res);
        pending_results.push_back(row.typed ? row.want : res);
        @(negedge i_clk);
    endtask

    function automatic logic [ID_W-1:0] random_target();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return ID_W'($urandom_range(MAX_THREADS + 1, 31));
        return ID_W'($urandom_range(1, MAX_THREADS));
    endfunction

    // Exits are kept rare so that the table does not die out early in the run.
    function automatic t_mode random_mode();
        int pick;
        pick = $urandom_range(0, 999);
        if (pick < 7) return MODE_EXIT;
        if (pick < ((next_id <= MAX_THREADS) ? 300 : 60)) return MODE_CREATE;
        return pick[0] ? MODE_YIELD : MODE_JOIN;
    endfunction

    function automatic void report(string field, int want, int got);
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        error_count++;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_sched_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result beat with none expected, expected nothing, actual status %0d",
                         $time, o_status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) report("status", want.status, o_status);
                if (o_running_id !== want.running_id)
                    report("running_id", want.running_id, o_running_id);
                if (o_new_id !== want.new_id) report("new_id", want.new_id, o_new_id);
                if (o_switched !== want.switched) report("switched", want.switched, o_switched);
            end
        end
    end

    // Receiver stalls in phases: none, light random, heavy random, and periodic.
    initial begin : stall_pattern
        int style;
        int phase_len;
        i_stall = 1'b0;
        forever begin
            style = $urandom_range(0, 3);
            phase_len = $urandom_range(8, 64);
            for (int k = 0; k < phase_len; k++) begin
                @(negedge i_clk);
                case (style)
                    0: i_stall = 1'b0;
                    1: i_stall = ($urandom_range(0, 3) == 0);
                    2: i_stall = ($urandom_range(0, 3) != 0);
                    default: i_stall = k[2];
                endcase
            end
        end
    end

    initial begin : stimulus
        t_event_row directed [25];
        t_event_row row;
        int waited;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_mode = MODE_CREATE;
        i_target_id = '0;
        error_count = 0;
        burst_left = 0;
        clear_scheduler();

        directed[0]  = make_row(MODE_YIELD,  0,  1, STS_NO_THREADS, 1, 0, 0);
        directed[1]  = make_row(MODE_EXIT,   0,  1, STS_NO_THREADS, 1, 0, 0);
        directed[2]  = make_row(MODE_JOIN,   5,  1, STS_NO_THREADS, 1, 0, 0);
        directed[3]  = make_row(MODE_CREATE, 0,  1, STS_OK,         1, 2, 0);
        directed[4]  = make_row(MODE_JOIN,   0,  1, STS_UNKNOWN,    1, 0, 0);
        directed[5]  = make_row(MODE_JOIN,   31, 1, STS_UNKNOWN,    1, 0, 0);
        directed[6]  = make_row(MODE_JOIN,   1,  1, STS_UNKNOWN,    1, 0, 0);
        directed[7]  = make_row(MODE_JOIN,   2,  0, STS_OK, 0, 0, 0);
        directed[8]  = make_row(MODE_YIELD,  0,  0, STS_OK, 0, 0, 0);
        directed[9]  = make_row(MODE_JOIN,   1,  0, STS_OK, 0, 0, 0);
        directed[10] = make_row(MODE_EXIT,   0,  0, STS_OK, 0, 0, 0);
        directed[11] = make_row(MODE_CREATE, 0,  0, STS_OK, 0, 0, 0);
        directed[12] = make_row(MODE_JOIN,   3,  0, STS_OK, 0, 0, 0);
        directed[13] = make_row(MODE_CREATE, 0,  0, STS_OK, 0, 0, 0);
        directed[14] = make_row(MODE_JOIN,   4,  0, STS_OK, 0, 0, 0);
        directed[15] = make_row(MODE_CREATE, 0,  0, STS_OK, 0, 0, 0);
        directed[16] = make_row(MODE_YIELD,  0,  0, STS_OK, 0, 0, 0);
        directed[17] = make_row(MODE_JOIN,   4,  0, STS_OK, 0, 0, 0);
        directed[18] = make_row(MODE_EXIT,   0,  0, STS_OK, 0, 0, 0);
        directed[19] = make_row(MODE_EXIT,   0,  0, STS_OK, 0, 0, 0);
        directed[20] = make_row(MODE_YIELD,  0,  0, STS_OK, 0, 0, 0);
        directed[21] = make_row(MODE_JOIN,   2,  0, STS_OK, 0, 0, 0);
        directed[22] = make_row(MODE_EXIT,   0,  0, STS_OK, 0, 0, 0);
        directed[23] = make_row(MODE_CREATE, 0,  0, STS_OK, 0, 0, 0);
        directed[24] = make_row(MODE_YIELD,  0,  0, STS_OK, 0, 0, 0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walks the empty table, bad join targets, joiner handover, the last thread exiting
        // and the rescan from id 1 once a new thread appears.
        foreach (directed[i]) send_event(directed[i]);

        // The table fills early on; create then keeps hitting the full case.
        for (int n = 0; n < RANDOM_EVENTS; n++) begin
            row.mode = random_mode();
            row.target = random_target();
            row.typed = 1'b0;
            row.want = '0;
            send_event(row);
        end
        i_valid = 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < 4000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (MAX_THREADS + 24) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t ns: results still expected, expected 0 left, actual %0d left",
                     $time, pending_results.size());
            error_count++;
        end

        if (error_count == 0) begin
            $display("** round_robin_thread_scheduler_core: PASSED **");
        end else begin
            $display("** round_robin_thread_scheduler_core: FAILED **");
        end
        $finish;
    end

endmodule
